/* rtl/core/srst_pkg.sv */
// shared types and codes for the sparse relation set table
`default_nettype none

package srst_pkg;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_GET   = 2'd1;
  localparam logic [1:0] FUNC_PURGE = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_GET    = 3'd1,
    OP_STORE  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_PURGE  = 3'd4
  } op_t;

  localparam int OP_BITS = 3;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_CLEAR = 4'b1000
  } eng_state_t;

  typedef struct packed {
    logic take;
    logic init_busy;
  } eng_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/srst_fifo.sv */
// small first-in first-out buffer of registers
`default_nettype none

module srst_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    store [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/srst_front.sv */
// front end: takes items, decodes them into table commands and queues them
`default_nettype none

module srst_front
  import srst_pkg::*;
#(
  parameter int KEY_BITS = 16,
  parameter int REL_BITS = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          func,
  input  logic [KEY_BITS-1:0] ident,
  input  logic [REL_BITS-1:0] rel_set,
  input  eng_ctrl_t           ctrl,
  output logic                cmd_valid,
  output op_t                 cmd_op,
  output logic [KEY_BITS-1:0] cmd_key,
  output logic [REL_BITS-1:0] cmd_set
);

  localparam int CMD_BITS = OP_BITS + KEY_BITS + REL_BITS;

  op_t                 op_dec;
  logic                q_full;
  logic                q_empty;
  logic [CMD_BITS-1:0] q_out;

  always_comb begin
    case (func)
      FUNC_ADD:   op_dec = (rel_set == '1) ? OP_REMOVE : OP_STORE;
      FUNC_GET:   op_dec = OP_GET;
      FUNC_PURGE: op_dec = OP_PURGE;
      default:    op_dec = OP_NOP;
    endcase
  end

  // no items taken while the table is being cleared after reset
  assign full = q_full || ctrl.init_busy;

  srst_fifo #(
    .WIDTH (CMD_BITS),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full),
    .wr_data ({op_dec, ident, rel_set}),
    .rd_en   (ctrl.take),
    .rd_data (q_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd_op    = op_t'(q_out[CMD_BITS-1 -: OP_BITS]);
  assign cmd_key   = q_out[REL_BITS +: KEY_BITS];
  assign cmd_set   = q_out[REL_BITS-1:0];

endmodule

`default_nettype wire

/* rtl/core/srst_engine.sv */
// back end: slot memory, sequential key search and table update
`default_nettype none

module srst_engine
  import srst_pkg::*;
#(
  parameter int SLOTS    = 16,
  parameter int KEY_BITS = 16,
  parameter int REL_BITS = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  op_t                 cmd_op,
  input  logic [KEY_BITS-1:0] cmd_key,
  input  logic [REL_BITS-1:0] cmd_set,
  output eng_ctrl_t           ctrl,
  input  logic                res_full,
  output logic                res_push,
  output logic                res_status,
  output logic [REL_BITS-1:0] res_read_set
);

  localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_BITS = $clog2(SLOTS + 1);

  logic                mem_valid [SLOTS];
  logic [KEY_BITS-1:0] mem_key   [SLOTS];
  logic [REL_BITS-1:0] mem_set   [SLOTS];

  eng_state_t          state;
  op_t                 op;
  logic [KEY_BITS-1:0] key;
  logic [REL_BITS-1:0] set;
  logic [CNT_BITS-1:0] addr;
  logic                pend;
  logic [IDX_BITS-1:0] pend_idx;
  logic                found;
  logic [IDX_BITS-1:0] hit_idx;
  logic [REL_BITS-1:0] hit_set;
  logic                free_found;
  logic [IDX_BITS-1:0] free_idx;
  logic                init;

  logic                rd_valid;
  logic [KEY_BITS-1:0] rd_key;
  logic [REL_BITS-1:0] rd_set;

  logic                issuing;
  logic                take;
  logic                wr_en;
  logic [IDX_BITS-1:0] wr_addr;
  logic                wr_valid;

  assign issuing = (state == ST_SCAN) && (addr != CNT_BITS'(SLOTS));
  assign take    = (state == ST_IDLE) && cmd_valid && !res_full;

  assign ctrl.take      = take;
  assign ctrl.init_busy = init;

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = addr[IDX_BITS-1:0];
    wr_valid = 1'b0;
    case (state)
      ST_CLEAR: wr_en = 1'b1;
      ST_APPLY: begin
        case (op)
          OP_STORE: begin
            if (found) begin
              wr_en    = 1'b1;
              wr_addr  = hit_idx;
              wr_valid = 1'b1;
            end else if (free_found) begin
              wr_en    = 1'b1;
              wr_addr  = free_idx;
              wr_valid = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (found) begin
              wr_en   = 1'b1;
              wr_addr = hit_idx;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_valid[wr_addr] <= wr_valid;
      mem_key[wr_addr]   <= key;
      mem_set[wr_addr]   <= set;
    end
  end

  always_ff @(posedge clk) begin
    if (issuing) begin
      rd_valid <= mem_valid[addr[IDX_BITS-1:0]];
      rd_key   <= mem_key[addr[IDX_BITS-1:0]];
      rd_set   <= mem_set[addr[IDX_BITS-1:0]];
    end
  end

  assign res_push     = (state == ST_APPLY);
  assign res_status   = (op == OP_STORE && !found && !free_found) ? STATUS_FULL : STATUS_OK;
  assign res_read_set = (op == OP_GET) ? (found ? hit_set : '1) : '0;

  always_ff @(posedge clk) begin
    if (take) begin
      op  <= cmd_op;
      key <= cmd_key;
      set <= cmd_set;
    end
    if (state == ST_SCAN && pend) begin
      if (rd_valid && rd_key == key && !found) begin
        hit_idx <= pend_idx;
        hit_set <= rd_set;
      end
      if (!rd_valid && !free_found) begin
        free_idx <= pend_idx;
      end
    end
    pend_idx <= addr[IDX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      addr       <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      init       <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            addr       <= '0;
            pend       <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            case (cmd_op)
              OP_GET, OP_STORE, OP_REMOVE: state <= ST_SCAN;
              OP_PURGE:                    state <= ST_CLEAR;
              default:                     state <= ST_APPLY;
            endcase
          end
        end
        ST_SCAN: begin
          pend <= issuing;
          if (issuing) begin
            addr <= addr + 1'b1;
          end
          if (pend) begin
            if (rd_valid && rd_key == key) begin
              found <= 1'b1;
            end
            if (!rd_valid) begin
              free_found <= 1'b1;
            end
          end
          if (!issuing && !pend) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: state <= ST_IDLE;
        ST_CLEAR: begin
          if (addr == CNT_BITS'(SLOTS - 1)) begin
            addr  <= '0;
            init  <= 1'b0;
            state <= init ? ST_IDLE : ST_APPLY;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sparse_relation_set_table.sv */
// top level of the sparse relation set table
//
// maps an identifier to a relation set; an identifier with no entry reads
// as the full set. input items enter through push/full with func, ident and
// rel_set; one result item per input item leaves through empty/pop with
// status and read_set, in input order.
// func add stores or overwrites a set (the full set removes the entry),
// reporting status 1 when a new entry finds no free slot; get returns the
// stored set or all ones; purge empties the table.
// a two-entry command queue parts the decoder from the table engine, and a
// two-entry result queue parts the engine from the receiver, so input is
// still taken while a result waits for pop.
// each add or get runs a search that reads one slot of the table memory
// per cycle; a purge clears one slot per cycle.
// after rst the engine clears the table with full held high; both queues
// come out of reset empty.
// while pop stays low and the result queue fills, the engine waits and the
// command queue then fills, raising full.
`default_nettype none

module sparse_relation_set_table
  import srst_pkg::*;
#(
  parameter int SLOTS    = 16,
  parameter int KEY_BITS = 16,
  parameter int REL_BITS = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          func,
  input  logic [KEY_BITS-1:0] ident,
  input  logic [REL_BITS-1:0] rel_set,
  output logic                empty,
  input  logic                pop,
  output logic                status,
  output logic [REL_BITS-1:0] read_set
);

  eng_ctrl_t           ctrl;
  logic                cmd_valid;
  op_t                 cmd_op;
  logic [KEY_BITS-1:0] cmd_key;
  logic [REL_BITS-1:0] cmd_set;
  logic                res_full;
  logic                res_push;
  logic                res_status;
  logic [REL_BITS-1:0] res_read_set;

  srst_front #(
    .KEY_BITS (KEY_BITS),
    .REL_BITS (REL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .ident     (ident),
    .rel_set   (rel_set),
    .ctrl      (ctrl),
    .cmd_valid (cmd_valid),
    .cmd_op    (cmd_op),
    .cmd_key   (cmd_key),
    .cmd_set   (cmd_set)
  );

  srst_engine #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS),
    .REL_BITS (REL_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_op       (cmd_op),
    .cmd_key      (cmd_key),
    .cmd_set      (cmd_set),
    .ctrl         (ctrl),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_status   (res_status),
    .res_read_set (res_read_set)
  );

  srst_fifo #(
    .WIDTH (1 + REL_BITS),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data ({res_status, res_read_set}),
    .rd_en   (pop),
    .rd_data ({status, read_set}),
    .full    (res_full),
    .empty   (empty)
  );

endmodule

`default_nettype wire

/* rtl/core/srst_checker.sv */
// port-level checks for the sparse relation set table, bound to the top level
`default_nettype none

module srst_checker
  import srst_pkg::*;
#(
  parameter int REL_BITS = 13
) (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic                status,
  input logic [REL_BITS-1:0] read_set
);

  // table clearing holds off input after reset
  a_reset_full: assert property (@(posedge clk) rst |=> full)
    else $error("full not raised after reset");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // a full-table report never carries a set
  a_full_no_set: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == STATUS_FULL) |-> (read_set == '0))
    else $error("read_set not zero with full status");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(read_set)))
    else $error("waiting item changed or vanished");

endmodule

bind sparse_relation_set_table srst_checker #(
  .REL_BITS (REL_BITS)
) u_srst_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .status   (status),
  .read_set (read_set)
);

`default_nettype wire
